>>> sv/plr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plr_pkg
// Shared types and constants of the light regulator: control word layout,
// microcode table, register indexes and fixed widths.
// ---------------------------------------------------------------------------
package plr_pkg;

	localparam int GAIN_W     = 16;
	localparam int ACC_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int DUTY_W     = 8;
	localparam int STEP_W     = 4;

	// output mapping (x + 100) * 255 / 200, clamped to the duty range
	localparam int DUTY_MAX    = 255;
	localparam int X_OFFSET    = 100;
	localparam int T_MAX       = 201;
	localparam int T_W         = 8;
	localparam int N_W         = 16;
	localparam int PRE_SHIFT   = 3;
	localparam int M_W         = N_W - PRE_SHIFT;
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 17;
	localparam int QP_W        = 2 * M_W;
	localparam int Q_W         = QP_W - RECIP_SHIFT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 4'd0,
		REG_PROP   = 4'd1,
		REG_INTEG  = 4'd2,
		REG_DERIV  = 4'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GSEL_P = 2'd0,
		GSEL_I = 2'd1,
		GSEL_D = 2'd2
	} gsel_t;

	typedef enum logic [1:0] {
		OUT_NONE      = 2'd0,
		OUT_LOAD_PROD = 2'd1,
		OUT_ADD_PROD  = 2'd2,
		OUT_ADD_ACC   = 2'd3
	} out_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT     = 2'd0,
		JMP_WAIT_IN  = 2'd1,
		JMP_WAIT_OUT = 2'd2
	} jmp_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic    ld_err;
		logic    mul_en;
		gsel_t   gsel;
		logic    mul_diff;
		out_op_t out_op;
		logic    acc_upd;
		logic    fin1;
		logic    fin2;
		logic    emit;
		jmp_t    jmp;
	} ucode_t;

	localparam step_t FIRST_STEP = 4'd0;
	localparam step_t EMIT_STEP  = 4'd8;

	function automatic ucode_t ucode(input step_t s);
		ucode_t uw;
		uw = '0;
		uw.gsel   = GSEL_P;
		uw.out_op = OUT_NONE;
		uw.jmp    = JMP_NEXT;
		case (s)
			4'd0: begin
				uw.ld_err = 1'b1;
				uw.jmp    = JMP_WAIT_IN;
			end
			4'd1: begin
				uw.mul_en = 1'b1;
				uw.gsel   = GSEL_P;
			end
			4'd2: begin
				uw.mul_en = 1'b1;
				uw.gsel   = GSEL_I;
				uw.out_op = OUT_LOAD_PROD;
			end
			4'd3: begin
				uw.mul_en   = 1'b1;
				uw.gsel     = GSEL_D;
				uw.mul_diff = 1'b1;
				uw.acc_upd  = 1'b1;
			end
			4'd4: begin
				uw.out_op = OUT_ADD_ACC;
			end
			4'd5: begin
				uw.out_op = OUT_ADD_PROD;
			end
			4'd6: begin
				uw.fin1 = 1'b1;
			end
			4'd7: begin
				uw.fin2 = 1'b1;
			end
			4'd8: begin
				uw.emit = 1'b1;
				uw.jmp  = JMP_WAIT_OUT;
			end
			default: begin
				uw.jmp = JMP_WAIT_OUT;
			end
		endcase
		return uw;
	endfunction

endpackage

>>> sv/plr_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plr_datapath
// Configuration registers, shared gain multiplier, integral accumulator and
// output mapping, driven one control word per step.
// ---------------------------------------------------------------------------
module plr_datapath #(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plr_pkg::ucode_t                ctrl,
	input  logic                           adv,
	input  logic                           cfg_we,
	input  logic [plr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [SAMPLE_BITS-1:0]         light_sample,
	output logic [plr_pkg::DUTY_W-1:0]     duty,
	output logic                           integ_cleared
);

	localparam int EW     = SAMPLE_BITS + 1;
	localparam int DW     = SAMPLE_BITS + 2;
	localparam int GW     = plr_pkg::GAIN_W;
	localparam int AW     = plr_pkg::ACC_W;
	localparam int PROD_W = GW + 1 + DW;
	localparam int SUM_W  = ((PROD_W > AW) ? PROD_W : AW) + 2;
	localparam int TW     = plr_pkg::T_W;
	localparam int YW     = plr_pkg::DUTY_W;

	localparam logic [GW-1:0] PROP_RST  = GW'(15 * (2 ** GAIN_FRAC_BITS) / 2);
	localparam logic [GW-1:0] INTEG_RST = GW'((2 * (2 ** GAIN_FRAC_BITS) + 5) / 10);
	localparam logic [GW-1:0] DERIV_RST = GW'((3 * (2 ** GAIN_FRAC_BITS) + 5) / 10);

	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-AW+1){1'b1}}, {(AW-1){1'b0}}};
	localparam logic signed [AW-1:0]    ACC_HI = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0]    ACC_LO = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] OUT_HI =
		SUM_W'(plr_pkg::DUTY_MAX * (2 ** GAIN_FRAC_BITS));

	logic [SAMPLE_BITS-1:0] target_q;
	logic [GW-1:0]          prop_q;
	logic [GW-1:0]          integ_q;
	logic [GW-1:0]          deriv_q;

	logic signed [EW-1:0]    err_q;
	logic signed [EW-1:0]    prev_err_q;
	logic signed [DW-1:0]    diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [AW-1:0]    acc_q;
	logic [TW-1:0]           t_q;
	logic [YW-1:0]           mapped_q;
	logic [YW-1:0]           prev_duty_q;
	logic [YW-1:0]           duty_q;
	logic                    cleared_q;
	logic                    flag_q;

	logic signed [EW-1:0]     err_c;
	logic signed [DW-1:0]     diff_c;
	logic [GW-1:0]            gain_c;
	logic signed [DW-1:0]     opnd_c;
	logic signed [PROD_W-1:0] ga_c;
	logic signed [PROD_W-1:0] ob_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [SUM_W-1:0]  prod_ext;
	logic signed [SUM_W-1:0]  acc_ext;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [AW-1:0]     acc_sat;
	logic                     clr_c;
	logic [SUM_W-1:0]         mag_c;
	logic [SUM_W-1:0]         xm_c;
	logic [TW-1:0]            t_c;
	logic [plr_pkg::N_W-1:0]  n_c;
	logic [plr_pkg::QP_W-1:0] qp_c;
	logic [plr_pkg::Q_W-1:0]  q_c;
	logic [YW-1:0]            mapped_c;
	logic [YW:0]              avg_c;

	// error and its change since the previous item
	assign err_c  = $signed({1'b0, target_q}) - $signed({1'b0, light_sample});
	assign diff_c = $signed({err_c[EW-1], err_c}) - $signed({prev_err_q[EW-1], prev_err_q});

	// shared gain multiplier
	always_comb begin
		case (ctrl.gsel)
			plr_pkg::GSEL_P: gain_c = prop_q;
			plr_pkg::GSEL_I: gain_c = integ_q;
			plr_pkg::GSEL_D: gain_c = deriv_q;
			default:         gain_c = '0;
		endcase
	end

	assign opnd_c = ctrl.mul_diff ? diff_q : $signed({err_q[EW-1], err_q});
	assign ga_c   = $signed({{(PROD_W-GW){1'b0}}, gain_c});
	assign ob_c   = $signed({{(PROD_W-DW){opnd_c[DW-1]}}, opnd_c});
	assign prod_c = ga_c * ob_c;

	assign prod_ext = $signed({{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
	assign acc_ext  = $signed({{(SUM_W-AW){acc_q[AW-1]}}, acc_q});

	// saturating integral update
	assign acc_sum = acc_ext + prod_ext;
	always_comb begin
		if (acc_sum > SAT_HI) begin
			acc_sat = ACC_HI;
		end else if (acc_sum < SAT_LO) begin
			acc_sat = ACC_LO;
		end else begin
			acc_sat = acc_sum[AW-1:0];
		end
	end

	// integral reset check and truncation toward zero, clamped offset
	assign clr_c = (sum_q >= OUT_HI) || (sum_q <= $signed({SUM_W{1'b0}}));
	assign mag_c = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign xm_c  = mag_c >> GAIN_FRAC_BITS;

	always_comb begin
		if (sum_q[SUM_W-1]) begin
			if (xm_c >= SUM_W'(plr_pkg::X_OFFSET)) begin
				t_c = '0;
			end else begin
				t_c = TW'(plr_pkg::X_OFFSET) - xm_c[TW-1:0];
			end
		end else begin
			if (xm_c >= SUM_W'(plr_pkg::T_MAX - plr_pkg::X_OFFSET)) begin
				t_c = TW'(plr_pkg::T_MAX);
			end else begin
				t_c = TW'(plr_pkg::X_OFFSET) + xm_c[TW-1:0];
			end
		end
	end

	// t * 255 / 200 by shift and reciprocal multiply
	assign n_c  = {t_q, {(plr_pkg::N_W-TW){1'b0}}} - {{(plr_pkg::N_W-TW){1'b0}}, t_q};
	assign qp_c = {{(plr_pkg::QP_W-plr_pkg::M_W){1'b0}}, n_c[plr_pkg::N_W-1:plr_pkg::PRE_SHIFT]}
		* plr_pkg::QP_W'(plr_pkg::RECIP);
	assign q_c  = qp_c[plr_pkg::QP_W-1:plr_pkg::RECIP_SHIFT];
	assign mapped_c = (q_c > plr_pkg::Q_W'(plr_pkg::DUTY_MAX)) ? YW'(plr_pkg::DUTY_MAX)
		: q_c[YW-1:0];

	assign avg_c = {1'b0, mapped_q} + {1'b0, prev_duty_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			prop_q      <= PROP_RST;
			integ_q     <= INTEG_RST;
			deriv_q     <= DERIV_RST;
			acc_q       <= '0;
			prev_err_q  <= '0;
			prev_duty_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					plr_pkg::REG_TARGET: target_q <= cfg_data[SAMPLE_BITS-1:0];
					plr_pkg::REG_PROP:   prop_q   <= cfg_data[GW-1:0];
					plr_pkg::REG_INTEG:  integ_q  <= cfg_data[GW-1:0];
					plr_pkg::REG_DERIV:  deriv_q  <= cfg_data[GW-1:0];
					default: ;
				endcase
			end
			if (adv) begin
				if (ctrl.acc_upd) begin
					acc_q <= acc_sat;
				end
				if (ctrl.fin1) begin
					prev_err_q <= err_q;
					if (clr_c) begin
						acc_q <= '0;
					end
				end
				if (ctrl.emit) begin
					prev_duty_q <= avg_c[YW:1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctrl.ld_err) begin
				err_q  <= err_c;
				diff_q <= diff_c;
			end
			if (ctrl.mul_en) begin
				prod_q <= prod_c;
			end
			case (ctrl.out_op)
				plr_pkg::OUT_LOAD_PROD: sum_q <= prod_ext;
				plr_pkg::OUT_ADD_PROD:  sum_q <= sum_q + prod_ext;
				plr_pkg::OUT_ADD_ACC:   sum_q <= sum_q + acc_ext;
				default: ;
			endcase
			if (ctrl.fin1) begin
				cleared_q <= clr_c;
				t_q       <= t_c;
			end
			if (ctrl.fin2) begin
				mapped_q <= mapped_c;
			end
			if (ctrl.emit) begin
				duty_q <= avg_c[YW:1];
				flag_q <= cleared_q;
			end
		end
	end

	assign duty          = duty_q;
	assign integ_cleared = flag_q;

endmodule

>>> sv/pid_light_regulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_light_regulator
// PID lamp regulation from a light sensor sample: microcoded sequencer over
// one shared gain multiplier, emits a smoothed 8-bit PWM duty per item.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    light_sample
//  out      out_valid / out_stall  duty, integ_cleared
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one item runs from acceptance to its result in the output register
//  through eight microcode steps after the accepting one, three of them
//  on the shared multiplier
//  the next item is taken in the cycle after the result is loaded, so a
//  new item is never taken while the last one is still in the program
//  in_stall stays high while a program runs; a stalled result holds the
//  sequencer at its last step until the output register frees
//  reset clears integral, previous error and previous duty; cfg_ready is
//  always high
// ---------------------------------------------------------------------------
module pid_light_regulator #(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SAMPLE_BITS-1:0]         light_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [plr_pkg::DUTY_W-1:0]     duty,
	output logic                           integ_cleared,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [plr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plr_pkg::CFG_DATA_W-1:0] cfg_data
);

	plr_pkg::step_t  step_q;
	plr_pkg::ucode_t ctrl;
	logic            out_valid_q;
	logic            in_accept;
	logic            out_free;
	logic            adv;

	assign ctrl      = plr_pkg::ucode(step_q);
	assign in_stall  = (ctrl.jmp != plr_pkg::JMP_WAIT_IN);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		case (ctrl.jmp)
			plr_pkg::JMP_WAIT_IN:  adv = in_accept;
			plr_pkg::JMP_WAIT_OUT: adv = out_free;
			default:               adv = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= plr_pkg::FIRST_STEP;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (ctrl.jmp == plr_pkg::JMP_WAIT_OUT) begin
					step_q <= plr_pkg::FIRST_STEP;
				end else begin
					step_q <= step_q + plr_pkg::STEP_W'(1);
				end
			end
			if (adv && ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	plr_datapath #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.adv          (adv),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.light_sample (light_sample),
		.duty         (duty),
		.integ_cleared(integ_cleared)
	);

	assign out_valid = out_valid_q;

	// sequencer never leaves the program
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= plr_pkg::EMIT_STEP)
		else $error("step counter out of program");

	// an accepted item starts the program
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (step_q == plr_pkg::FIRST_STEP + plr_pkg::STEP_W'(1)) && in_stall)
		else $error("accepted item did not start program");

	// a result appears only from the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q) == plr_pkg::EMIT_STEP)
		else $error("result without emit step");

	// back at the first step only after a result was loaded
	a_return: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == plr_pkg::EMIT_STEP) && out_free |=> out_valid_q
			&& (step_q == plr_pkg::FIRST_STEP))
		else $error("emit step left without a result");

endmodule

>>> dv/pid_light_regulator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_light_regulator_tb
// Self-checking bench for the PID light regulator. A cycle-free model of the
// controller (error, saturating integral with clear, derivative, output map
// and duty smoothing) predicts each duty from the accepted samples and the
// register settings. Directed corners come first, then random phases with
// new setpoints and gains, random idling on both channels, a long output
// hold-off and drains between phases.
// ---------------------------------------------------------------------------
module pid_light_regulator_tb;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 8;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int MAP_SPAN    = 200;
	localparam int MAX_GAP     = 17;
	localparam int HOLD_CYCLES = 250;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam longint ACC_HI     = 64'sd2147483647;
	localparam longint ACC_LO     = -64'sd2147483648;
	localparam longint FULL_SCALE = longint'(plr_pkg::DUTY_MAX) <<< FRAC_BITS;

	typedef struct {
		logic [plr_pkg::DUTY_W-1:0] duty;
		logic                       cleared;
	} duty_item_t;

	class pid_duty_model;
		logic [SAMPLE_BITS-1:0]     setpoint;
		logic [plr_pkg::GAIN_W-1:0] kp, ki, kd;
		longint                     integ;
		int                         last_err;
		logic [plr_pkg::DUTY_W-1:0] last_duty;
		duty_item_t                 due[$];
		int                         fails;

		function new();
			setpoint  = '0;
			kp        = 16'd1920;
			ki        = 16'd51;
			kd        = 16'd77;
			integ     = 0;
			last_err  = 0;
			last_duty = '0;
			fails     = 0;
		endfunction

		function void apply_reg(logic [plr_pkg::CFG_IDX_W-1:0] idx,
			logic [plr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				plr_pkg::REG_TARGET: setpoint = data[SAMPLE_BITS-1:0];
				plr_pkg::REG_PROP:   kp = data;
				plr_pkg::REG_INTEG:  ki = data;
				plr_pkg::REG_DERIV:  kd = data;
				default: ;
			endcase
		endfunction

		function void predict_tick(logic [SAMPLE_BITS-1:0] s);
			int         err;
			longint     p, d, total, whole, mapped;
			duty_item_t e;
			err = int'(setpoint) - int'(s);
			p = longint'(kp) * err;
			integ = integ + longint'(ki) * err;
			if (integ > ACC_HI)
				integ = ACC_HI;
			if (integ < ACC_LO)
				integ = ACC_LO;
			d = longint'(kd) * (err - last_err);
			total = p + integ + d;
			e.cleared = (total >= FULL_SCALE || total <= 0);
			if (e.cleared)
				integ = 0;
			if (total < 0)
				whole = -((-total) >>> FRAC_BITS);
			else
				whole = total >>> FRAC_BITS;
			mapped = (whole + plr_pkg::X_OFFSET) * plr_pkg::DUTY_MAX / MAP_SPAN;
			if (mapped < 0)
				mapped = 0;
			if (mapped > plr_pkg::DUTY_MAX)
				mapped = plr_pkg::DUTY_MAX;
			e.duty = plr_pkg::DUTY_W'((mapped + longint'(last_duty)) >> 1);
			last_duty = e.duty;
			last_err = err;
			due.push_back(e);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		task check_duty(logic [plr_pkg::DUTY_W-1:0] got_duty, logic got_cleared);
			duty_item_t e;
			if (due.size() == 0) begin
				report($sformatf("duty %0d with no item pending", got_duty));
			end else begin
				e = due.pop_front();
				if (got_duty !== e.duty)
					report($sformatf("duty %0d, want %0d", got_duty, e.duty));
				if (got_cleared !== e.cleared)
					report($sformatf("integ_cleared %0b, want %0b", got_cleared, e.cleared));
			end
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [SAMPLE_BITS-1:0]         light_sample;
	logic                           out_valid;
	logic                           out_stall;
	logic [plr_pkg::DUTY_W-1:0]     duty;
	logic                           integ_cleared;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [plr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [plr_pkg::CFG_DATA_W-1:0] cfg_data;

	pid_duty_model regulator = new();
	int            tx_mode;
	int            rx_mode;
	int            hold_req;
	int            target;

	pid_light_regulator #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.GAIN_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.light_sample(light_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty(duty),
		.integ_cleared(integ_cleared),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// mode 0: no idling, 1: uniform gaps, 2: mostly back to back
	function automatic int draw_gap(int mode);
		int g;
		g = 0;
		if (mode == 1)
			g = $urandom_range(0, MAX_GAP);
		else if (mode == 2 && $urandom_range(0, 3) == 0)
			g = $urandom_range(1, MAX_GAP);
		return g;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] next_sample(int sp);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, SAMPLE_MAX);
			1: v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
			default: v = sp + int'($urandom_range(0, 300)) - 150;
		endcase
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [plr_pkg::GAIN_W-1:0] rand_gain(int span);
		logic [plr_pkg::GAIN_W-1:0] g;
		case ($urandom_range(0, 7))
			0: g = '0;
			1: g = '1;
			2: g = plr_pkg::GAIN_W'($urandom);
			default: g = plr_pkg::GAIN_W'($urandom_range(0, span));
		endcase
		return g;
	endfunction

	task automatic write_reg(input logic [plr_pkg::CFG_IDX_W-1:0] idx,
		input logic [plr_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		regulator.apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		light_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (regulator.pending() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				regulator.predict_tick(light_sample);
			if (out_valid && !out_stall)
				regulator.check_duty(duty, integ_cleared);
		end
	end

	// output side: stall for a drawn number of cycles, or for the long hold-off when one is requested, then take one item
	initial begin
		int gap;
		int holds_taken;
		holds_taken = 0;
		out_stall   = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req != holds_taken) begin
				gap         = HOLD_CYCLES;
				holds_taken = hold_req;
			end else begin
				gap = draw_gap(rx_mode);
			end
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin
		logic [SAMPLE_BITS-1:0] corners[6];
		logic [SAMPLE_BITS-1:0] near[9];
		corners = '{12'd0, 12'hFFF, 12'hAAA, 12'h555, 12'd1, 12'd0};
		near = '{12'd1900, 12'd1950, 12'd1990, 12'd2000, 12'd2010, 12'd2050,
			12'd2100, 12'd2200, 12'd1990};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		light_sample = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		tx_mode      = 0;
		rx_mode      = 0;
		hold_req     = 0;
		target       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, setpoint zero
		foreach (corners[i])
			send_sample(corners[i], 0);
		wait_results();

		// every register at its top, setpoint written with spare upper bits set
		write_reg(plr_pkg::REG_TARGET, '1);
		write_reg(plr_pkg::REG_PROP, '1);
		write_reg(plr_pkg::REG_INTEG, '1);
		write_reg(plr_pkg::REG_DERIV, '1);
		send_sample(12'd0, 0);
		send_sample(12'hFFF, 0);
		send_sample(12'd0, 0);
		send_sample(12'd2048, 0);
		wait_results();

		// moderate gains: outputs inside the map, negative outputs, clamping
		write_reg(plr_pkg::REG_TARGET, 16'd2000);
		write_reg(plr_pkg::REG_PROP, 16'd256);
		write_reg(plr_pkg::REG_INTEG, 16'd8);
		write_reg(plr_pkg::REG_DERIV, 16'd64);
		write_reg(plr_pkg::CFG_IDX_W'($urandom_range(plr_pkg::REG_DERIV + 1,
			(1 << plr_pkg::CFG_IDX_W) - 1)), '0);
		foreach (near[i])
			send_sample(near[i], 0);
		wait_results();

		// all gains zero
		write_reg(plr_pkg::REG_PROP, '0);
		write_reg(plr_pkg::REG_INTEG, '0);
		write_reg(plr_pkg::REG_DERIV, '0);
		send_sample(12'd0, 0);
		send_sample(12'hFFF, 0);
		wait_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: target = 0;
				1: target = SAMPLE_MAX;
				default: target = $urandom_range(0, SAMPLE_MAX);
			endcase
			write_reg(plr_pkg::REG_TARGET, {4'($urandom), 12'(target)});
			write_reg(plr_pkg::REG_PROP, rand_gain(2048));
			write_reg(plr_pkg::REG_INTEG, rand_gain(128));
			write_reg(plr_pkg::REG_DERIV, rand_gain(512));
			if ($urandom_range(0, 2) == 0)
				write_reg(plr_pkg::CFG_IDX_W'($urandom_range(plr_pkg::REG_DERIV + 1,
					(1 << plr_pkg::CFG_IDX_W) - 1)), plr_pkg::CFG_DATA_W'($urandom));
			tx_mode = ph % 3;
			rx_mode = (ph / 3) % 3;
			if (ph == 4 || ph == 9) begin
				tx_mode  = 0;
				hold_req = hold_req + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(next_sample(target), draw_gap(tx_mode));
			wait_results();
		end

		repeat (20) @(posedge clk);
		if (regulator.fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
sv/plr_pkg.sv
sv/plr_datapath.sv
sv/pid_light_regulator.sv
dv/pid_light_regulator_tb.sv
